// ----- sv/gna_pkg.sv -----
// shared types and constants for the neighbor aggregation unit
`default_nettype none
package gna_pkg;
	localparam int MaxChannels = 64;
	localparam int ChW = $clog2(MaxChannels);

	localparam logic [0:0] RegActiveChannels = 1'b0;
	localparam logic [0:0] RegReluEnable = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic start_div;
		logic div_step;
		logic sqrt_step;
		logic mul;
		logic acc;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic last;
		logic div_done;
		logic sqrt_done;
	} status_t;
endpackage
`default_nettype wire

// ----- sv/gna_ctrl.sv -----
// controller state machine for the neighbor aggregation unit
`default_nettype none
module gna_ctrl import gna_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t sts,
	output cmd_t         cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIV;
			ST_DIV: begin
				if (!sts.active) state_d = ST_IDLE;
				else if (sts.div_done) state_d = ST_SQRT;
			end
			ST_SQRT: if (sts.sqrt_done) state_d = ST_MUL;
			ST_MUL: state_d = ST_ACC;
			ST_ACC: state_d = sts.last ? ST_OUT : ST_IDLE;
			ST_OUT: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV: cmd.div_step = sts.active;
			ST_SQRT: cmd.sqrt_step = 1'b1;
			ST_MUL: cmd.mul = 1'b1;
			ST_ACC: cmd.acc = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("output dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("in and out overlap");
	a_acc_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul |=> cmd.acc) else $error("acc missing");
`endif
endmodule
`default_nettype wire

// ----- sv/gna_datapath.sv -----
// datapath: degree product divide, integer sqrt, scale, accumulate
`default_nettype none
module gna_datapath import gna_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output status_t          sts,
	input  wire logic [6:0]  active_channels,
	input  wire logic        relu_enable,
	input  wire logic [31:0] message_value,
	input  wire logic [31:0] bias_value,
	input  wire logic [15:0] node_degree,
	input  wire logic [15:0] neighbor_degree,
	input  wire logic [5:0]  channel,
	input  wire logic        last_neighbor,
	output logic [31:0]      hidden_value,
	output logic [5:0]       channel_index,
	output logic             node_done
);
	logic signed [31:0] msg_q, bias_q;
	logic [15:0] nd_q, md_q;
	logic [ChW-1:0] ch_q;
	logic last_q, active_q, done_q;
	logic [6:0] eff;
	// two restoring dividers run together: 2^32/(nd*md) and |bias|/nd
	logic [31:0] prod_q;
	logic [32:0] quo_q;
	logic [33:0] rem_q;
	logic [31:0] bq_q;
	logic [32:0] brem_q;
	logic [5:0] cnt_q;
	logic [16:0] s_q;
	logic [4:0] bit_q;
	logic signed [31:0] acc_q [MaxChannels];
	logic [MaxChannels-1:0] acc_vld_q;
	logic signed [31:0] acc_rd_q;
	logic acc_rd_vld_q;
	logic signed [31:0] acc_cur;
	logic signed [49:0] prod_s1;
	logic signed [31:0] res_q;

	assign eff = (active_channels > 7'(MaxChannels)) ? 7'(MaxChannels) : active_channels;
	assign sts.active = active_q;
	assign sts.last = last_q;
	assign sts.div_done = (cnt_q == 6'd32);
	assign sts.sqrt_done = (bit_q == 5'd0);

	logic [32:0] brem_sh;
	logic [16:0] s_try;
	logic [33:0] sq;
	always_comb begin
		brem_sh = {brem_q[31:0], bq_q[31]};
		s_try = s_q | (17'd1 << (bit_q - 5'd1));
		sq = 34'(s_try) * 34'(s_try);
	end

	logic signed [33:0] floorv;
	logic signed [33:0] biasq;
	logic signed [34:0] sum;
	always_comb begin
		acc_cur = acc_rd_vld_q ? acc_rd_q : '0;
		floorv = 34'(prod_s1 >>> 16);
		biasq = bias_q[31] ? -$signed({2'b0, bq_q}) : $signed({2'b0, bq_q});
		sum = 35'(acc_cur) + 35'(floorv) + 35'(biasq);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			msg_q <= message_value;
			bias_q <= bias_value;
			nd_q <= (node_degree == 16'd0) ? 16'd1 : node_degree;
			md_q <= (neighbor_degree == 16'd0) ? 16'd1 : neighbor_degree;
			ch_q <= channel;
			last_q <= last_neighbor;
			active_q <= {1'b0, channel} < eff;
			done_q <= 7'(channel) + 7'd1 == eff;
			cnt_q <= 6'd0;
			rem_q <= '0;
			quo_q <= '0;
			bq_q <= bias_value[31] ? 32'(-bias_value) : bias_value;
			brem_q <= '0;
			s_q <= '0;
			bit_q <= 5'd17;
			prod_q <= '0;
		end
		if (cmd.div_step) begin
			if (cnt_q == 6'd0) begin
				prod_q <= nd_q * md_q;
				cnt_q <= 6'd1;
				rem_q <= 34'd1;
			end else begin
				// 2^32 dividend: a single one bit then zeros
				if ({rem_q[32:0], 1'b0} >= {2'b0, prod_q}) begin
					rem_q <= {rem_q[32:0], 1'b0} - {2'b0, prod_q};
					quo_q <= {quo_q[31:0], 1'b1};
				end else begin
					rem_q <= {rem_q[32:0], 1'b0};
					quo_q <= {quo_q[31:0], 1'b0};
				end
				if (brem_sh >= {17'b0, nd_q}) begin
					brem_q <= brem_sh - {17'b0, nd_q};
					bq_q <= {bq_q[30:0], 1'b1};
				end else begin
					brem_q <= brem_sh;
					bq_q <= {bq_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
		end
		if (cmd.sqrt_step) begin
			if (sq <= {1'b0, quo_q} + ((rem_q >= {2'b0, prod_q}) ? 34'd1 : 34'd0))
				s_q <= s_try;
			bit_q <= bit_q - 5'd1;
		end
		if (cmd.mul) prod_s1 <= 50'(msg_q) * $signed({33'b0, s_q});
		if (cmd.acc) begin
			if (sum > 35'sh7FFFFFFF) res_q <= 32'h7FFFFFFF;
			else if (sum < -35'sh80000000) res_q <= 32'h80000000;
			else res_q <= sum[31:0];
		end
	end

	// accumulator store, read into a register during the multiply cycle
	always_ff @(posedge clk) begin
		if (cmd.mul) acc_rd_q <= acc_q[ch_q];
		if (cmd.acc) begin
			if (last_q) acc_q[ch_q] <= '0;
			else if (sum > 35'sh7FFFFFFF) acc_q[ch_q] <= 32'h7FFFFFFF;
			else if (sum < -35'sh80000000) acc_q[ch_q] <= 32'h80000000;
			else acc_q[ch_q] <= sum[31:0];
		end
	end

	// an entry not written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
			acc_rd_vld_q <= 1'b0;
		end else begin
			if (cmd.mul) acc_rd_vld_q <= acc_vld_q[ch_q];
			if (cmd.acc) acc_vld_q[ch_q] <= 1'b1;
		end
	end

	assign hidden_value = (relu_enable && res_q[31]) ? 32'd0 : res_q;
	assign channel_index = 6'(ch_q);
	assign node_done = done_q;
endmodule
`default_nettype wire

// ----- sv/gcn_neighbor_aggregate_unit.sv -----
// top level of the gcn neighbor aggregation unit
//
// one channel of one neighbor message per input transaction on s_axis;
// tdata packs message, bias, both degrees and channel, tlast marks the
// final neighbor of the node. the accumulator of the channel gets
// floor(msg*s/2^16) + bias/node_degree, saturated, where s = 1/sqrt of the
// degree product in Q1.16. on the final neighbor the channel value leaves
// on m_axis (tdata = value, channel; tlast = node done) and is cleared.
// steps: idle, divide (setup, 32 steps), square root (17 trials, exit),
// multiply, accumulate, then output on the final neighbor; one item at a
// time, the next input is taken only once the unit is back in idle.
// an inactive channel goes from divide back to idle and gives no output.
// a stalled m_axis holds its transaction and blocks new input.
// reset marks all 64 accumulators unwritten, so they read as zero, and loads active_channels 64, relu on.
// cfg writes are accepted every cycle; index 0 active_channels, 1 relu.
`default_nettype none
module gcn_neighbor_aggregate_unit import gna_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// message[31:0] bias[63:32] node_degree[79:64] neighbor_degree[95:80] channel[101:96]
	input  wire logic [103:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// hidden_value[31:0] channel_index[37:32]
	output logic [39:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [6:0]  cfg_data
);
	cmd_t cmd;
	status_t sts;
	logic [6:0] active_channels_q;
	logic relu_enable_q;
	logic [31:0] hidden_value;
	logic [5:0] channel_index;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_channels_q <= 7'd64;
			relu_enable_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				RegActiveChannels: active_channels_q <= cfg_data;
				RegReluEnable: relu_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	gna_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.sts(sts), .cmd(cmd)
	);

	gna_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.active_channels(active_channels_q), .relu_enable(relu_enable_q),
		.message_value(s_axis_tdata[31:0]), .bias_value(s_axis_tdata[63:32]),
		.node_degree(s_axis_tdata[79:64]), .neighbor_degree(s_axis_tdata[95:80]),
		.channel(s_axis_tdata[101:96]), .last_neighbor(s_axis_tlast),
		.hidden_value(hidden_value), .channel_index(channel_index),
		.node_done(m_axis_tlast)
	);

	// output transaction payload
	assign m_axis_tdata = {2'b0, channel_index, hidden_value};
endmodule
`default_nettype wire

// ----- verif/tb_gcn_neighbor_aggregate_unit.sv -----
// self-checking testbench for the gcn neighbor aggregation unit
`default_nettype none
module tb_gcn_neighbor_aggregate_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import gna_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles = 80;

	// one predicted output transaction
	typedef struct {
		logic [31:0] hidden;
		logic [5:0]  chan;
		logic        done;
	} hidden_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// message[31:0] bias[63:32] node_degree[79:64] neighbor_degree[95:80] channel[101:96]
	logic [103:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// hidden_value[31:0] channel_index[37:32]
	logic [39:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	// predictor state
	logic [6:0] pred_active;
	logic pred_relu;
	logic signed [31:0] pred_acc [MaxChannels];
	hidden_t hidden_q[$];

	int errors = 0;
	int sent = 0;
	int received = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit rx_mode = 0;

	always #2 clk = ~clk;

	gcn_neighbor_aggregate_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// largest s in [0, 131071] with s*s <= q
	function automatic logic [16:0] norm_root(logic [63:0] q);
		logic [63:0] s;
		logic [63:0] t;
		s = '0;
		for (int b = 16; b >= 0; b--) begin
			t = s | (64'd1 << b);
			if (t * t <= q) s = t;
		end
		return s[16:0];
	endfunction

	// predict one accepted input transaction
	function automatic void predict_aggregate(logic [103:0] d, logic last);
		logic signed [63:0] msg, bias, prod, fl, sum;
		logic [63:0] nd, md, s;
		logic [6:0] eff;
		logic [5:0] ch;
		hidden_t h;
		msg = 64'($signed(d[31:0]));
		bias = 64'($signed(d[63:32]));
		nd = 64'(d[79:64]);
		md = 64'(d[95:80]);
		ch = d[101:96];
		eff = (pred_active > MaxChannels) ? 7'(MaxChannels) : pred_active;
		if ({1'b0, ch} >= eff) return;
		if (nd == 64'd0) nd = 64'd1;
		if (md == 64'd0) md = 64'd1;
		s = 64'(norm_root((64'd1 << 32) / (nd * md)));
		prod = msg * $signed(s);
		// floor division by 2^16 is an arithmetic shift
		fl = prod >>> 16;
		sum = pred_acc[ch] + fl + bias / $signed(nd);
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		pred_acc[ch] = sum[31:0];
		if (!last) return;
		h.hidden = (pred_relu && pred_acc[ch] < 0) ? 32'd0 : pred_acc[ch];
		h.chan = ch;
		h.done = ({1'b0, ch} + 7'd1 == eff);
		pred_acc[ch] = '0;
		hidden_q = {hidden_q, h};
	endfunction

	// receiver: stall pattern alternates between a free-running and a choppy mode
	always @(posedge clk) begin
		if (($urandom_range(0, 99)) == 0) rx_mode <= ~rx_mode;
		m_axis_tready <= rx_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
	end

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		hidden_t h;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			received++;
			if (hidden_q.size() == 0) begin
				$error("unexpected output transaction %h", m_axis_tdata);
				errors++;
			end else begin
				h = hidden_q.pop_front();
				if (m_axis_tdata[31:0] !== h.hidden) begin
					$error("hidden_value expected %h got %h", h.hidden, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[37:32] !== h.chan) begin
					$error("channel_index expected %0d got %0d", h.chan, m_axis_tdata[37:32]);
					errors++;
				end
				if (m_axis_tlast !== h.done) begin
					$error("node_done expected %0d got %0d", h.done, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("[gcn_neighbor_aggregate_unit] ERROR");
			$finish;
		end
	end

	// send one input item, with bursty gaps before it
	task automatic send_item(logic signed [31:0] msg, logic signed [31:0] bias,
			logic [15:0] nd, logic [15:0] md, logic [5:0] ch, logic last);
		if (burst_left == 0) begin
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 60);
			burst_left = $urandom_range(1, 12);
		end
		if (gap_left != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap_left) @(posedge clk);
		end
		gap_left = 0;
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, ch, md, nd, bias, msg};
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_aggregate({2'b00, ch, md, nd, bias, msg}, last);
		sent++;
	endtask

	// wait for all predictions, then let a dropped item finish
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (hidden_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [6:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == RegActiveChannels) pred_active = val;
		else pred_relu = val[0];
	endtask

	// extremes of every field, zero degrees, saturation, relu both ways
	task automatic test_directed();
		send_item(32'sh7fffffff, 32'sh7fffffff, 16'd1, 16'd1, 6'd0, 1'b0);
		send_item(32'sh7fffffff, 32'sh7fffffff, 16'd0, 16'd0, 6'd0, 1'b1);
		send_item(-32'sh80000000, -32'sh80000000, 16'd1, 16'd1, 6'd1, 1'b0);
		send_item(-32'sh80000000, -32'sh80000000, 16'd1, 16'd0, 6'd1, 1'b1);
		send_item(32'sh00010000, -32'sh00030000, 16'hffff, 16'hffff, 6'd63, 1'b1);
		send_item(-32'sh00050000, 32'sh00000007, 16'd3, 16'd5, 6'd2, 1'b1);
		write_reg(RegReluEnable, 7'd0);
		send_item(-32'sh00050000, 32'sh00000007, 16'd3, 16'd5, 6'd2, 1'b1);
		send_item(32'sh12345678, -32'sh00000009, 16'd2, 16'hffff, 6'd63, 1'b1);
		write_reg(RegActiveChannels, 7'd4);
		send_item(32'sh00020000, 32'sh0, 16'd1, 16'd1, 6'd5, 1'b1);   // inactive
		send_item(32'sh00020000, 32'sh0, 16'd1, 16'd1, 6'd3, 1'b1);   // node done
		write_reg(RegActiveChannels, 7'd1);
		send_item(-32'sh00020000, 32'sh1, 16'd4, 16'd4, 6'd0, 1'b1);
		write_reg(RegActiveChannels, 7'd0);
		send_item(32'sh00020000, 32'sh1, 16'd1, 16'd1, 6'd0, 1'b1);   // all ignored
		write_reg(RegActiveChannels, 7'd127);
		send_item(32'sh00020000, 32'sh1, 16'd1, 16'd1, 6'd63, 1'b1);  // clamped to 64
		write_reg(RegActiveChannels, 7'd64);
		write_reg(RegReluEnable, 7'd1);
	endtask

	// random nodes: neighbors stream channels 0 to at most 7, then the final neighbor
	task automatic test_random_nodes(int items, logic [6:0] chans, logic relu);
		int n;
		logic [15:0] nd;
		int nbrs;
		write_reg(RegActiveChannels, chans);
		write_reg(RegReluEnable, {6'd0, relu});
		n = 0;
		while (n < items) begin
			nd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
			nbrs = $urandom_range(1, 3);
			for (int k = 0; k < nbrs; k++) begin
				logic [15:0] md;
				md = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 9));
				for (int c = 0; c < chans && c < MaxChannels && c < 8; c++) begin
					if ($urandom_range(0, 19) == 0)
						// noise: random channel and random last flag
						send_item($urandom, $urandom, 16'($urandom), 16'($urandom),
							6'($urandom), 1'($urandom_range(0, 1)));
					else
						send_item(($urandom_range(0, 3) == 0) ? $urandom
								: $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000,
							($urandom_range(0, 3) == 0) ? $urandom
								: $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000,
							nd, md, 6'(c), k == nbrs - 1);
					n++;
				end
			end
		end
	endtask

	// the sender holds off until every result is back, then continues
	task automatic test_full_pause();
		wait_drained();
		send_item($urandom, $urandom, 16'd1, 16'd1, 6'd0, 1'b1);
	endtask

	initial begin
		for (int i = 0; i < MaxChannels; i++) pred_acc[i] = '0;
		pred_active = 7'd64;
		pred_relu = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_nodes(250, 7'd8, 1'b0);
		test_full_pause();
		test_random_nodes(200, 7'd3, 1'b1);
		test_random_nodes(200, 7'd64, 1'b0);
		test_random_nodes(150, 7'd1, 1'b1);
		wait_drained();
		$display("covered %0d input items and %0d results over several channel counts,",
			sent, received);
		$display("relu on and off, zero and extreme degrees, saturation and ignored channels");
		if (errors == 0)
			$display("[gcn_neighbor_aggregate_unit] OK");
		else
			$display("[gcn_neighbor_aggregate_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
